FILE: hw/rtl/tbae_pkg.sv
`default_nettype none

package tbae_pkg;

    // Field and register widths.
    localparam int SAMPLE_W = 12;
    localparam int SLOPE_W  = 17;
    localparam int ICPT_W   = 16;
    localparam int TEMP_W   = 8;
    localparam int AVG_W    = 24;
    localparam int SUM_W    = 32;

    // One converted sample in Q8.8. Its magnitude stays below 2^21.
    localparam int T_W = 22;

    // Reset values of the registers and of the running average (35.0 C).
    localparam int SLOPE_RESET = -7602;
    localparam int ICPT_RESET  = 12518;
    localparam int AVG_RESET   = 8960;

    // Default number of samples per block.
    localparam int BLOCK_SIZE_DEF = 64;

    // Register map, indexed by paddr[2].
    localparam logic REG_SLOPE = 1'b0;
    localparam logic REG_ICPT  = 1'b1;

    typedef struct packed {
        logic [TEMP_W-1:0]        temperature_c;
        logic signed [AVG_W-1:0]  average_q8;
    } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/temperature_block_average_ema_unit.sv
`default_nettype none

// Channel    Direction  Handshake              Payload
// input      in         in_valid / in_ready    sample_mv
// output     out        out_valid / out_ready  temperature_c, average_q8
// config     in         APB (psel, penable)    slope_q16 at 0x0, intercept_q8 at 0x4
//
// One sample transaction is taken per clock unless the input is held back. A sample goes
// through an input register and a multiply stage, then it is added into the block sum.
// The last sample of a block hands its sum to the update sequencer (mean divide, weighted
// add, divide by three, result write), which takes no new sum until it is idle again.
// Reset clears the sample counter and the block sum and sets the running average to 35.0 C.
// A result waiting at the output does not block samples; only a block end that finds
// the sequencer busy, as when its result write waits on the output, holds the input back.

module temperature_block_average_ema_unit #(
    parameter int BLOCK_SIZE = tbae_pkg::BLOCK_SIZE_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [tbae_pkg::SAMPLE_W-1:0]        sample_mv,

    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [tbae_pkg::TEMP_W-1:0]               temperature_c,
    output logic signed [tbae_pkg::AVG_W-1:0]         average_q8,

    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [2:0]                           paddr,
    input  wire logic [31:0]                          pwdata,
    output logic [31:0]                               prdata,
    output logic                                      pready
);

    localparam int CNT_W  = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
    localparam int SW     = tbae_pkg::SLOPE_W;
    localparam int IW     = tbae_pkg::ICPT_W;
    localparam int TW     = tbae_pkg::T_W;
    localparam int SUMW   = tbae_pkg::SUM_W;
    localparam int PW     = SW + tbae_pkg::SAMPLE_W + 1;

    // Configuration registers.
    logic signed [SW-1:0]   slope_reg;
    logic signed [IW-1:0]   icpt_reg;
    logic                   cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slope_reg <= SW'(tbae_pkg::SLOPE_RESET);
            icpt_reg  <= IW'(tbae_pkg::ICPT_RESET);
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                tbae_pkg::REG_SLOPE: slope_reg <= pwdata[SW-1:0];
                tbae_pkg::REG_ICPT:  icpt_reg  <= pwdata[IW-1:0];
                default:             slope_reg <= slope_reg;
            endcase
        end
    end

    // Reads return the register sign-extended to the bus width.
    always_comb
    begin
        case (paddr[2])
            tbae_pkg::REG_SLOPE: prdata = {{(32-SW){slope_reg[SW-1]}}, slope_reg};
            tbae_pkg::REG_ICPT:  prdata = {{(32-IW){icpt_reg[IW-1]}}, icpt_reg};
            default:             prdata = '0;
        endcase
    end

    // Sample pipeline: input register, then the converted sample, then accumulation.
    logic [tbae_pkg::SAMPLE_W-1:0] mv_reg;
    logic                          s0_valid_reg;
    logic signed [TW-1:0]          t_reg;
    logic                          s1_valid_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic signed [SUMW-1:0]        block_sum_reg;

    logic signed [PW-1:0]          prod;
    logic signed [TW-1:0]          t_next;
    logic signed [SUMW-1:0]        sum_total;
    logic                          s1_last;
    logic                          s1_fire;
    logic                          s0_fire;
    logic                          in_fire;
    logic                          upd_ready;
    tbae_pkg::result_t             upd_result;

    // floor(slope * mv / 256) is the arithmetic shift of the product; it fits in T_W bits.
    assign prod    = slope_reg * $signed({1'b0, mv_reg});
    assign t_next  = $signed(prod[PW-2:8]) + TW'(icpt_reg);

    assign sum_total = block_sum_reg + SUMW'(t_reg);
    assign s1_last   = (cnt_reg == CNT_W'(BLOCK_SIZE - 1));
    assign s1_fire   = s1_valid_reg && (!s1_last || upd_ready);
    assign s0_fire   = s0_valid_reg && (!s1_valid_reg || s1_fire);
    assign in_ready  = !s0_valid_reg || s0_fire;
    assign in_fire   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            cnt_reg       <= '0;
            block_sum_reg <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                s0_valid_reg <= 1'b1;
            end
            else if (s0_fire)
            begin
                s0_valid_reg <= 1'b0;
            end

            if (s0_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            // The last sample of a block leaves with the sum and restarts the count.
            if (s1_fire)
            begin
                if (s1_last)
                begin
                    cnt_reg       <= '0;
                    block_sum_reg <= '0;
                end
                else
                begin
                    cnt_reg       <= cnt_reg + CNT_W'(1);
                    block_sum_reg <= sum_total;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mv_reg <= sample_mv;
        end
        if (s0_fire)
        begin
            t_reg <= t_next;
        end
    end

    // Block-end update of the running average and the output register.
    tbae_ema_update #(
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_update (
        .clk          (clk),
        .rst_n        (rst_n),
        .sum_valid    (s1_valid_reg && s1_last),
        .sum_ready    (upd_ready),
        .sum          (sum_total),
        .result       (upd_result),
        .result_valid (out_valid),
        .result_ready (out_ready)
    );

    assign temperature_c = upd_result.temperature_c;
    assign average_q8    = upd_result.average_q8;

`ifndef SYNTH
    // The sample counter never reaches the block size.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(BLOCK_SIZE - 1))
        else $error("sample counter out of range");

    // Handing off a block empties the accumulator.
    a_block_clear: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_last |=> block_sum_reg == '0 && cnt_reg == '0)
        else $error("accumulator not cleared after block end");

    // The accumulator only moves when a converted sample is consumed.
    a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_fire |=> $stable(block_sum_reg) && $stable(cnt_reg))
        else $error("accumulator changed without a sample");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/tbae_ema_update.sv
`default_nettype none

module tbae_ema_update #(
    parameter int BLOCK_SIZE = tbae_pkg::BLOCK_SIZE_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   sum_valid,
    output logic                                        sum_ready,
    input  wire logic signed [tbae_pkg::SUM_W-1:0]      sum,
    output tbae_pkg::result_t                           result,
    output logic                                        result_valid,
    input  wire logic                                   result_ready
);

    // The block sum magnitude stays below 2^31, so mean = floor(mag * RECIP_N / 2^SHIFT_N)
    // is exact with a reciprocal that fits in 32 bits.
    localparam int MAG_W    = 31;
    localparam int RCP_W    = 32;
    localparam int CLOG_N   = $clog2(BLOCK_SIZE);
    localparam int SHIFT_N  = MAG_W + CLOG_N;
    localparam logic [63:0] RECIP_N_FULL =
        ((64'd1 << SHIFT_N) + 64'(BLOCK_SIZE) - 64'd1) / 64'(BLOCK_SIZE);
    localparam logic [RCP_W-1:0] RECIP_N = RECIP_N_FULL[RCP_W-1:0];
    localparam int PROD_W   = MAG_W + RCP_W;
    localparam int Q_W      = tbae_pkg::T_W;
    localparam int MEAN_W   = Q_W + 1;

    // Division by three of the weighted sum, same method.
    localparam int X_W      = tbae_pkg::AVG_W + 2;
    localparam int MAG3_W   = X_W - 1;
    localparam int SHIFT_3  = MAG3_W + 2;
    localparam int RCP3_W   = 26;
    localparam logic [RCP3_W-1:0] RECIP_3 = 26'd44739243;
    localparam int PROD3_W  = MAG3_W + RCP3_W;
    localparam int AW       = tbae_pkg::AVG_W;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_ABS  = 8'b0000_0010,
        ST_MULN = 8'b0000_0100,
        ST_MEAN = 8'b0000_1000,
        ST_SUM3 = 8'b0001_0000,
        ST_ABS3 = 8'b0010_0000,
        ST_MUL3 = 8'b0100_0000,
        ST_UPD  = 8'b1000_0000
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic signed [tbae_pkg::SUM_W-1:0] sum_reg;
    logic                            neg_reg;
    logic [MAG_W-1:0]                mag_reg;
    logic [PROD_W-1:0]               prod_reg;
    logic signed [MEAN_W-1:0]        mean_reg;
    logic signed [X_W-1:0]           x_reg;
    logic                            neg3_reg;
    logic [MAG3_W-1:0]               mag3_reg;
    logic [PROD3_W-1:0]              prod3_reg;
    logic signed [AW-1:0]            avg_reg;
    logic signed [AW-1:0]            avg_next;
    tbae_pkg::result_t               result_reg;
    logic                            result_valid_reg;

    logic [tbae_pkg::SUM_W-1:0]      sum_abs;
    logic [Q_W-1:0]                  q_n;
    logic [X_W-1:0]                  x_abs;
    logic [AW-1:0]                   q3;
    logic [tbae_pkg::TEMP_W-1:0]     temp_next;
    logic                            slot_free;

    assign slot_free = !result_valid_reg || result_ready;
    assign sum_ready = (state_reg == ST_IDLE);

    assign sum_abs = sum_reg[tbae_pkg::SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
    assign q_n     = prod_reg[SHIFT_N +: Q_W];
    assign x_abs   = x_reg[X_W-1] ? (~x_reg + 1'b1) : x_reg;
    assign q3      = prod3_reg[SHIFT_3 +: AW];
    assign avg_next = neg3_reg ? $signed(~q3 + 1'b1) : $signed(q3);

    // Whole degrees, truncated toward zero, clamped to 0..255.
    always_comb
    begin
        if (avg_next[AW-1])
        begin
            temp_next = '0;
        end
        else if (avg_next[AW-2:16] != '0)
        begin
            temp_next = '1;
        end
        else
        begin
            temp_next = avg_next[15:8];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sum_valid)
                begin
                    state_next = ST_ABS;
                end
            end
            ST_ABS:  state_next = ST_MULN;
            ST_MULN: state_next = ST_MEAN;
            ST_MEAN: state_next = ST_SUM3;
            ST_SUM3: state_next = ST_ABS3;
            ST_ABS3: state_next = ST_MUL3;
            ST_MUL3: state_next = ST_UPD;
            ST_UPD:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            avg_reg          <= AW'(tbae_pkg::AVG_RESET);
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_UPD && slot_free)
            begin
                avg_reg          <= avg_next;
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && sum_valid)
        begin
            sum_reg <= sum;
        end
        if (state_reg == ST_ABS)
        begin
            neg_reg <= sum_reg[tbae_pkg::SUM_W-1];
            mag_reg <= sum_abs[MAG_W-1:0];
        end
        if (state_reg == ST_MULN)
        begin
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(RECIP_N);
        end
        if (state_reg == ST_MEAN)
        begin
            mean_reg <= neg_reg ? $signed(~{1'b0, q_n} + 1'b1) : $signed({1'b0, q_n});
        end
        if (state_reg == ST_SUM3)
        begin
            x_reg <= $signed({avg_reg[AW-1], avg_reg, 1'b0})
                   + $signed({{(X_W-MEAN_W){mean_reg[MEAN_W-1]}}, mean_reg});
        end
        if (state_reg == ST_ABS3)
        begin
            neg3_reg <= x_reg[X_W-1];
            mag3_reg <= x_abs[MAG3_W-1:0];
        end
        if (state_reg == ST_MUL3)
        begin
            prod3_reg <= PROD3_W'(mag3_reg) * PROD3_W'(RECIP_3);
        end
        if (state_reg == ST_UPD && slot_free)
        begin
            result_reg.temperature_c <= temp_next;
            result_reg.average_q8    <= avg_next;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

`ifndef SYNTH
    // A negative average must report zero whole degrees.
    a_neg_clamps: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.average_q8[AW-1] |-> result_reg.temperature_c == '0)
        else $error("negative average not clamped to zero");

    // In-range averages report their integer part.
    a_whole_deg: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_reg.average_q8[AW-1]
        && result_reg.average_q8[AW-2:16] == '0
        |-> result_reg.temperature_c == result_reg.average_q8[15:8])
        else $error("whole degrees do not match average");

    // Finishing an update always presents a result next cycle.
    a_upd_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPD && slot_free |=> result_valid_reg && state_reg == ST_IDLE)
        else $error("update finished without result");

    // The running average only changes when a result is produced.
    a_avg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg == ST_UPD && slot_free) |=> $stable(avg_reg))
        else $error("running average changed outside an update");
`endif

endmodule

`default_nettype wire
